// ===== hdl/tcpr_pkg.sv =====
// Shared types, codes and constants for the trigger command packet receiver.
// Holds the CRC-16 byte update function and the result bit layout.
// Depends on nothing.
package tcpr_pkg;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_PULSE = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PULSE = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  localparam logic [7:0] OP_SET_DELAY = 8'h01;
  localparam logic [7:0] OP_SET_TOTAL = 8'h02;
  localparam logic [7:0] OP_INIT      = 8'h03;
  localparam logic [7:0] OP_START     = 8'h04;

  localparam logic REG_IDX_HEADER  = 1'b0;
  localparam logic REG_IDX_TIMEOUT = 1'b1;

  localparam logic [7:0]  HEADER_RST  = 8'h02;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [31:0] DELAY_RST   = 32'd10000;
  localparam logic [31:0] TOTAL_RST   = 32'd10;
  localparam logic [31:0] PULSES_RST  = 32'd1;
  localparam logic [15:0] CRC_POLY    = 16'h8005;
  localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

  // Parameter byte counters are compared after extension to this width.
  localparam int CNT_EXT_W = 3;

  // Result payload layout, lowest bit first.
  localparam int OD_CRC_MATCH = 0;
  localparam int OD_INSTR_LO  = 1;
  localparam int OD_PARAM_LO  = 9;
  localparam int OD_START_P   = 41;
  localparam int OD_START_S   = 42;
  localparam int OD_DLY_LOAD  = 43;
  localparam int OD_DELAY_LO  = 44;
  localparam int OD_STOP_P    = 76;
  localparam int OD_COUNT_LO  = 77;
  localparam int OD_TOTAL_LO  = 109;
  localparam int OUT_DATA_W   = 144;

  typedef struct packed {
    logic [1:0]  kind;
    logic        crc_match;
    logic [7:0]  instruction;
    logic [31:0] parameter_res;
  } tcpr_rec_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/tcpr_front.sv =====
// Front part: idle timer, packet deframing and CRC check.
// Turns each accepted event into one record for the queue. Uses tcpr_pkg.
module tcpr_front import tcpr_pkg::*; #(
  parameter int PARAM_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  input  logic [7:0] header_byte,
  input  logic [15:0] idle_timeout,
  output tcpr_rec_t  rec
);

  localparam int PCW = (PARAM_BYTES > 1) ? $clog2(PARAM_BYTES) : 1;
  localparam logic [PCW-1:0] PCNT_LAST = PCW'(PARAM_BYTES - 1);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_INST   = 3'd2;
  localparam logic [2:0] PH_PARAM  = 3'd3;
  localparam logic [2:0] PH_CRC_L  = 3'd4;
  localparam logic [2:0] PH_CRC_H  = 3'd5;

  logic [2:0]     phase_r, phase_nxt, phase_eff;
  logic [PCW-1:0] pcnt_r, pcnt_nxt, pcnt_eff;
  logic [15:0]    crc_r, crc_nxt;
  logic [7:0]     instr_r, instr_nxt;
  logic [31:0]    param_r, param_nxt;
  logic [7:0]     crc_lo_r, crc_lo_nxt;
  logic [15:0]    idle_r, idle_nxt;
  logic [CNT_EXT_W-1:0] pcnt_ext;
  logic [15:0]    crc_got;

  always_comb begin
    phase_nxt  = phase_r;
    pcnt_nxt   = pcnt_r;
    crc_nxt    = crc_r;
    instr_nxt  = instr_r;
    param_nxt  = param_r;
    crc_lo_nxt = crc_lo_r;
    idle_nxt   = idle_r;
    rec        = '0;
    rec.kind   = KIND_NONE;
    phase_eff  = (idle_r > idle_timeout) ? PH_HEADER : phase_r;
    pcnt_eff   = (idle_r > idle_timeout) ? '0 : pcnt_r;
    pcnt_ext   = CNT_EXT_W'(pcnt_eff);
    crc_got    = {data_byte, crc_lo_r};
    case (command)
      CMD_TICK: begin
        if (idle_r != IDLE_MAX) begin
          idle_nxt = idle_r + 16'd1;
        end
      end
      CMD_PULSE: begin
        rec.kind = KIND_PULSE;
      end
      CMD_BYTE: begin
        idle_nxt  = '0;
        phase_nxt = phase_eff;
        pcnt_nxt  = pcnt_eff;
        case (phase_eff)
          PH_LENGTH: begin
            crc_nxt   = crc16_update(crc_r, data_byte);
            phase_nxt = PH_INST;
          end
          PH_INST: begin
            instr_nxt = data_byte;
            crc_nxt   = crc16_update(crc_r, data_byte);
            phase_nxt = PH_PARAM;
          end
          PH_PARAM: begin
            for (int i = 0; i < 4; i++) begin
              if (pcnt_ext == CNT_EXT_W'(i)) begin
                param_nxt[8*i +: 8] = param_r[8*i +: 8] | data_byte;
              end
            end
            crc_nxt = crc16_update(crc_r, data_byte);
            if (pcnt_eff == PCNT_LAST) begin
              pcnt_nxt  = '0;
              phase_nxt = PH_CRC_L;
            end else begin
              pcnt_nxt = pcnt_eff + PCW'(1);
            end
          end
          PH_CRC_L: begin
            crc_lo_nxt = data_byte;
            phase_nxt  = PH_CRC_H;
          end
          PH_CRC_H: begin
            rec.kind  = KIND_FRAME;
            phase_nxt = PH_HEADER;
            pcnt_nxt  = '0;
            if (crc_got == crc_r) begin
              rec.crc_match     = 1'b1;
              rec.instruction   = instr_r;
              rec.parameter_res = param_r;
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
            pcnt_nxt  = '0;
            if (data_byte == header_byte) begin
              crc_nxt   = crc16_update(16'h0000, data_byte);
              instr_nxt = '0;
              param_nxt = '0;
              phase_nxt = PH_LENGTH;
            end
          end
        endcase
      end
      default: begin
        rec.kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pcnt_r   <= '0;
      crc_r    <= '0;
      instr_r  <= '0;
      param_r  <= '0;
      crc_lo_r <= '0;
      idle_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      pcnt_r   <= pcnt_nxt;
      crc_r    <= crc_nxt;
      instr_r  <= instr_nxt;
      param_r  <= param_nxt;
      crc_lo_r <= crc_lo_nxt;
      idle_r   <= idle_nxt;
    end
  end

endmodule

// ===== hdl/tcpr_queue.sv =====
// Short record queue between the front and back parts.
// Register file with head and tail pointers and a fill count. Uses tcpr_pkg.
module tcpr_queue import tcpr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tcpr_rec_t push_rec,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output tcpr_rec_t head_rec
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tcpr_rec_t       entry_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head_rec  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/tcpr_back.sv =====
// Back part: runs decoded packets and pulse events on the trigger state.
// Owns the delay, total and pulse counter and the result register. Uses tcpr_pkg.
module tcpr_back import tcpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rec_valid,
  input  tcpr_rec_t             rec,
  output logic                  rec_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  logic [31:0] delay_r, delay_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] pulses_r, pulses_nxt;
  logic [31:0] pulse_inc;
  logic        valid_r;
  logic        last_r, last_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic        start_p, start_s, dly_load, stop_p;

  assign rec_take  = rec_valid && (!valid_r || out_ready);
  assign pulse_inc = pulses_r + 32'd1;

  always_comb begin
    delay_nxt  = delay_r;
    total_nxt  = total_r;
    pulses_nxt = pulses_r;
    start_p    = 1'b0;
    start_s    = 1'b0;
    dly_load   = 1'b0;
    stop_p     = 1'b0;
    last_nxt   = 1'b0;
    case (rec.kind)
      KIND_PULSE: begin
        if (pulse_inc == total_r) begin
          stop_p     = 1'b1;
          pulses_nxt = '0;
        end else begin
          pulses_nxt = pulse_inc;
        end
      end
      KIND_FRAME: begin
        last_nxt = 1'b1;
        if (rec.crc_match) begin
          case (rec.instruction)
            OP_SET_DELAY: begin
              delay_nxt = rec.parameter_res;
            end
            OP_SET_TOTAL: begin
              total_nxt = rec.parameter_res;
            end
            OP_INIT: begin
              pulses_nxt = '0;
              total_nxt  = 32'd1;
              start_p    = 1'b1;
            end
            OP_START: begin
              pulses_nxt = '0;
              start_p    = 1'b1;
              start_s    = 1'b1;
              dly_load   = 1'b1;
            end
            default: begin
              start_p = 1'b0;
            end
          endcase
        end
      end
      default: begin
        last_nxt = 1'b0;
      end
    endcase
    data_nxt = '0;
    data_nxt[OD_CRC_MATCH]         = rec.crc_match;
    data_nxt[OD_INSTR_LO +: 8]     = rec.instruction;
    data_nxt[OD_PARAM_LO +: 32]    = rec.parameter_res;
    data_nxt[OD_START_P]           = start_p;
    data_nxt[OD_START_S]           = start_s;
    data_nxt[OD_DLY_LOAD]          = dly_load;
    data_nxt[OD_DELAY_LO +: 32]    = delay_nxt;
    data_nxt[OD_STOP_P]            = stop_p;
    data_nxt[OD_COUNT_LO +: 32]    = pulses_nxt;
    data_nxt[OD_TOTAL_LO +: 32]    = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RST;
      total_r  <= TOTAL_RST;
      pulses_r <= PULSES_RST;
      valid_r  <= 1'b0;
    end else begin
      if (rec_take) begin
        delay_r  <= delay_nxt;
        total_r  <= total_nxt;
        pulses_r <= pulses_nxt;
        valid_r  <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      data_r <= data_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule

// ===== hdl/trigger_command_packet_receiver.sv =====
// Top level of the trigger command packet receiver.
// Holds the configuration registers and joins front, queue and back. Uses tcpr_pkg.
//
//   channel  direction  contents
//   in_      slave      one event: tuser = command, tdata = received byte
//   out_     master     one result per event, tlast = end of frame
//   cfg_     APB        header byte at 0x0, idle timeout at 0x4
//
// One event is taken every cycle unless the queue is full; results are registered.
// The CRC update of a byte is done within the front cycle, so nothing iterates.
// Reset is synchronous and immediate; no clearing pass follows it.
// The queue absorbs up to QUEUE_DEPTH events while the result side stalls.
module trigger_command_packet_receiver import tcpr_pkg::*; #(
  parameter int PARAM_BYTES = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic [1:0]            in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // crc_match, instruction, parameter_res, start_primary, start_secondary,
  // delay_load, delay_value, stop_primary, pulse_count, pulse_total, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // frame_end
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [7:0]  header_r;
  logic [15:0] timeout_r;
  logic        cfg_wr;
  logic        in_accept;
  logic        q_full, q_not_empty, q_pop;
  tcpr_rec_t   front_rec, head_rec;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_TIMEOUT) ? {16'h0000, timeout_r}
                                                        : {24'h000000, header_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_IDX_HEADER) begin
        header_r <= cfg_pwdata[7:0];
      end else begin
        timeout_r <= cfg_pwdata[15:0];
      end
    end
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && !q_full;

  tcpr_front #(.PARAM_BYTES(PARAM_BYTES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .command      (in_tuser),
    .data_byte    (in_tdata),
    .header_byte  (header_r),
    .idle_timeout (timeout_r),
    .rec          (front_rec)
  );

  tcpr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_rec  (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  tcpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_not_empty),
    .rec       (head_rec),
    .rec_take  (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== hdl/tcpr_checker.sv =====
// Port-level checks on the result channel of the trigger command packet receiver.
// Bound to the top level at the end of this file. Uses tcpr_pkg.
module tcpr_checker import tcpr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_start_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OD_START_S] |-> out_tdata[OD_START_P] && out_tdata[OD_DLY_LOAD]
      && out_tdata[OD_COUNT_LO +: 32] == 32'd0)
    else $error("full run start is incomplete");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OD_STOP_P] |-> out_tdata[OD_COUNT_LO +: 32] == 32'd0
      && !out_tlast)
    else $error("stop without cleared pulse count");

  a_match_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[OD_CRC_MATCH] && !out_tdata[OD_START_P]
      && out_tdata[OD_INSTR_LO +: 8] == 8'h00)
    else $error("packet fields outside a frame end");

endmodule

bind trigger_command_packet_receiver tcpr_checker u_tcpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
